// ----- design/ttim_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttim_pkg
// Shared types and constants of the tensor transpose index map unit.
// ----------------------------------------------------------------------------
package ttim_pkg;

  // number of dimension size registers
  localparam int SIZE_REGS = 4;
  localparam int SEL_BITS  = 2;
  localparam int COUNT_BITS = 3;
  localparam int PERM_BITS = 8;
  localparam int CFG_IDX_BITS = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIM_COUNT = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIM0_SIZE = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIM1_SIZE = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIM2_SIZE = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIM3_SIZE = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PERM_MAP  = 3'd5;

  localparam logic [COUNT_BITS-1:0] DIM_COUNT_RST = 3'd1;
  localparam logic [PERM_BITS-1:0]  PERM_MAP_RST  = 8'd228;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_BAD_PERM = 2'd2
  } status_t;

endpackage

// ----- design/ttim_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttim_if
// Valid/ready channels of the tensor transpose index map unit.
// ----------------------------------------------------------------------------
interface ttim_in_if #(
  parameter int INDEX_BITS = 24
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] out_index;

  modport source (output valid, output out_index, input ready);
  modport sink   (input valid, input out_index, output ready);
endinterface

interface ttim_out_if
  import ttim_pkg::*;
#(
  parameter int INDEX_BITS = 24
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] src_index;
  status_t               status;

  modport source (output valid, output src_index, output status, input ready);
  modport sink   (input valid, input src_index, input status, output ready);
endinterface

// ----- design/ttim_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttim_div_cell
// One restoring division step: takes the next dividend bit, produces one
// quotient bit and hands the partial remainder to the next cell.
// ----------------------------------------------------------------------------
module ttim_div_cell
  import ttim_pkg::*;
#(
  parameter int INDEX_BITS = 24,
  parameter int DIM_BITS   = 13,
  parameter int DIM_IDX    = 0,
  parameter bit LAST       = 1'b0
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic [DIM_BITS-1:0]                  divisor,
  input  logic                                 valid_in,
  input  logic [DIM_BITS-1:0]                  rem_in,
  input  logic [INDEX_BITS-1:0]                quo_in,
  input  logic [SIZE_REGS-1:0][DIM_BITS-1:0]   coord_in,
  output logic                                 valid_out,
  output logic [DIM_BITS-1:0]                  rem_out,
  output logic [INDEX_BITS-1:0]                quo_out,
  output logic [SIZE_REGS-1:0][DIM_BITS-1:0]   coord_out
);

  logic                                valid_r;
  logic [DIM_BITS-1:0]                 rem_r;
  logic [INDEX_BITS-1:0]               quo_r;
  logic [SIZE_REGS-1:0][DIM_BITS-1:0]  coord_r;
  logic [SIZE_REGS-1:0][DIM_BITS-1:0]  coord_nxt;

  logic [DIM_BITS:0]   trial;
  logic                ge;
  logic [DIM_BITS:0]   diff;
  logic [DIM_BITS-1:0] rem_step;

  assign trial    = {rem_in, quo_in[INDEX_BITS-1]};
  assign ge       = trial >= {1'b0, divisor};
  assign diff     = ge ? (trial - {1'b0, divisor}) : trial;
  assign rem_step = diff[DIM_BITS-1:0];

  always_comb begin
    coord_nxt = coord_in;
    if (LAST) begin
      // remainder of the last step is this dimension's coordinate
      coord_nxt[DIM_IDX] = rem_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r   <= {quo_in[INDEX_BITS-2:0], ge};
      coord_r <= coord_nxt;
      rem_r   <= LAST ? '0 : rem_step;
    end
  end

  assign valid_out = valid_r;
  assign rem_out   = rem_r;
  assign quo_out   = quo_r;
  assign coord_out = coord_r;

endmodule

// ----- design/ttim_comp_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttim_comp_cell
// One re-flatten step: adds the selected coordinate times the running
// product and extends the running product by this dimension's size.
// ----------------------------------------------------------------------------
module ttim_comp_cell
  import ttim_pkg::*;
#(
  parameter int INDEX_BITS = 24,
  parameter int DIM_BITS   = 13
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 dim_used,
  input  logic [SEL_BITS-1:0]                  sel,
  input  logic [DIM_BITS-1:0]                  dim_size,
  input  logic                                 valid_in,
  input  logic                                 rerr_in,
  input  logic [INDEX_BITS-1:0]                src_in,
  input  logic [INDEX_BITS-1:0]                factor_in,
  input  logic [SIZE_REGS-1:0][DIM_BITS-1:0]   coord_in,
  output logic                                 valid_out,
  output logic                                 rerr_out,
  output logic [INDEX_BITS-1:0]                src_out,
  output logic [INDEX_BITS-1:0]                factor_out,
  output logic [SIZE_REGS-1:0][DIM_BITS-1:0]   coord_out
);

  logic                                valid_r;
  logic                                rerr_r;
  logic [INDEX_BITS-1:0]               src_r;
  logic [INDEX_BITS-1:0]               factor_r;
  logic [SIZE_REGS-1:0][DIM_BITS-1:0]  coord_r;

  logic [DIM_BITS+INDEX_BITS-1:0] term;
  logic [DIM_BITS+INDEX_BITS-1:0] fprod;

  assign term  = (DIM_BITS+INDEX_BITS)'(coord_in[sel]) *
                 (DIM_BITS+INDEX_BITS)'(factor_in);
  assign fprod = (DIM_BITS+INDEX_BITS)'(factor_in) *
                 (DIM_BITS+INDEX_BITS)'(dim_size);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rerr_r   <= rerr_in;
      coord_r  <= coord_in;
      factor_r <= fprod[INDEX_BITS-1:0];
      src_r    <= dim_used ? (src_in + term[INDEX_BITS-1:0]) : src_in;
    end
  end

  assign valid_out  = valid_r;
  assign rerr_out   = rerr_r;
  assign src_out    = src_r;
  assign factor_out = factor_r;
  assign coord_out  = coord_r;

endmodule

// ----- design/tensor_transpose_index_map_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tensor_transpose_index_map_unit
// Maps output flat indexes of a tensor transpose to source flat indexes.
// ----------------------------------------------------------------------------
// usage
//   in_ch carries output flat indexes, out_ch returns the source index and a
//   status (ok, index beyond element count, bad permutation entry). The
//   source index is zero whenever status is not ok.
//   cfg_we/cfg_idx/cfg_data write dim_count, the four dimension sizes and
//   the permutation map; write them only while the unit is drained.
// timing
//   one transfer per cycle in and out while out_ch is not stalled. The path
//   is a chain of 4*INDEX_BITS restoring division cells, one quotient bit per
//   cell, then four re-flatten cells, then the output register.
// reset
//   rst_n clears the pipeline and loads the register defaults: one
//   dimension, all sizes one, identity permutation.
// stall
//   while out_ch is stalled a skid register catches the result in flight;
//   in_ch.ready drops only when the skid register is full, and the whole
//   chain then holds.
// ----------------------------------------------------------------------------
module tensor_transpose_index_map_unit
  import ttim_pkg::*;
#(
  parameter int MAX_DIMS   = 4,
  parameter int INDEX_BITS = 24,
  parameter int DIM_BITS   = 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ttim_in_if.sink              in_ch,
  ttim_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [((DIM_BITS > PERM_BITS) ? DIM_BITS : PERM_BITS)-1:0] cfg_data
);

  localparam int DIM_LIM = (MAX_DIMS < SIZE_REGS) ? MAX_DIMS : SIZE_REGS;
  localparam int ND      = SIZE_REGS * INDEX_BITS;

  // configuration registers
  logic [COUNT_BITS-1:0] dim_count_r;
  logic [DIM_BITS-1:0]   size_r [SIZE_REGS];
  logic [PERM_BITS-1:0]  perm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_count_r <= DIM_COUNT_RST;
      for (int i = 0; i < SIZE_REGS; i++) begin
        size_r[i] <= DIM_BITS'(1);
      end
      perm_r <= PERM_MAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DIM_COUNT: dim_count_r <= cfg_data[COUNT_BITS-1:0];
        CFG_DIM0_SIZE: size_r[0]   <= cfg_data[DIM_BITS-1:0];
        CFG_DIM1_SIZE: size_r[1]   <= cfg_data[DIM_BITS-1:0];
        CFG_DIM2_SIZE: size_r[2]   <= cfg_data[DIM_BITS-1:0];
        CFG_DIM3_SIZE: size_r[3]   <= cfg_data[DIM_BITS-1:0];
        CFG_PERM_MAP:  perm_r      <= cfg_data[PERM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // decode of the static configuration
  logic [COUNT_BITS-1:0] n_use;
  logic [SIZE_REGS-1:0]  dim_used;
  logic                  bad_perm;
  logic                  zero_size;

  assign n_use = (dim_count_r > COUNT_BITS'(DIM_LIM)) ? COUNT_BITS'(DIM_LIM)
                                                      : dim_count_r;

  always_comb begin
    bad_perm  = 1'b0;
    zero_size = 1'b0;
    for (int j = 0; j < SIZE_REGS; j++) begin
      dim_used[j] = COUNT_BITS'(j) < n_use;
      if (dim_used[j] && (COUNT_BITS'(perm_r[2*j +: SEL_BITS]) >= n_use)) begin
        bad_perm = 1'b1;
      end
      if (dim_used[j] && (size_r[j] == '0)) begin
        zero_size = 1'b1;
      end
    end
  end

  // chain enable and skid stage
  logic                  skid_valid_r;
  logic [INDEX_BITS-1:0] skid_src_r;
  status_t               skid_status_r;
  logic                  out_valid_r;
  logic [INDEX_BITS-1:0] out_src_r;
  status_t               out_status_r;
  logic                  en;

  assign en          = !skid_valid_r;
  assign in_ch.ready = en;

  // division chain
  logic                               dv_valid [0:ND];
  logic [DIM_BITS-1:0]                dv_rem   [0:ND];
  logic [INDEX_BITS-1:0]              dv_quo   [0:ND];
  logic [SIZE_REGS-1:0][DIM_BITS-1:0] dv_coord [0:ND];

  assign dv_valid[0] = in_ch.valid;
  assign dv_rem[0]   = '0;
  assign dv_quo[0]   = in_ch.out_index;
  assign dv_coord[0] = '0;

  for (genvar k = 0; k < ND; k++) begin : g_div
    localparam int DI = k / INDEX_BITS;
    logic [DIM_BITS-1:0] divisor;
    // unused dimensions divide by one
    assign divisor = dim_used[DI] ? size_r[DI] : DIM_BITS'(1);
    ttim_div_cell #(
      .INDEX_BITS (INDEX_BITS),
      .DIM_BITS   (DIM_BITS),
      .DIM_IDX    (DI),
      .LAST       ((k % INDEX_BITS) == (INDEX_BITS - 1))
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .divisor   (divisor),
      .valid_in  (dv_valid[k]),
      .rem_in    (dv_rem[k]),
      .quo_in    (dv_quo[k]),
      .coord_in  (dv_coord[k]),
      .valid_out (dv_valid[k+1]),
      .rem_out   (dv_rem[k+1]),
      .quo_out   (dv_quo[k+1]),
      .coord_out (dv_coord[k+1])
    );
  end

  // re-flatten chain
  logic                               cp_valid  [0:SIZE_REGS];
  logic                               cp_rerr   [0:SIZE_REGS];
  logic [INDEX_BITS-1:0]              cp_src    [0:SIZE_REGS];
  logic [INDEX_BITS-1:0]              cp_factor [0:SIZE_REGS];
  logic [SIZE_REGS-1:0][DIM_BITS-1:0] cp_coord  [0:SIZE_REGS];

  // a quotient left over after all dimensions means index beyond the count
  assign cp_valid[0]  = dv_valid[ND];
  assign cp_rerr[0]   = dv_quo[ND] != '0;
  assign cp_src[0]    = '0;
  assign cp_factor[0] = INDEX_BITS'(1);
  assign cp_coord[0]  = dv_coord[ND];

  for (genvar j = 0; j < SIZE_REGS; j++) begin : g_comp
    ttim_comp_cell #(
      .INDEX_BITS (INDEX_BITS),
      .DIM_BITS   (DIM_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .dim_used   (dim_used[j]),
      .sel        (perm_r[2*j +: SEL_BITS]),
      .dim_size   (size_r[j]),
      .valid_in   (cp_valid[j]),
      .rerr_in    (cp_rerr[j]),
      .src_in     (cp_src[j]),
      .factor_in  (cp_factor[j]),
      .coord_in   (cp_coord[j]),
      .valid_out  (cp_valid[j+1]),
      .rerr_out   (cp_rerr[j+1]),
      .src_out    (cp_src[j+1]),
      .factor_out (cp_factor[j+1]),
      .coord_out  (cp_coord[j+1])
    );
  end

  // result of the last cell
  status_t               res_status;
  logic [INDEX_BITS-1:0] res_src;
  logic                  res_valid;

  always_comb begin
    priority if (bad_perm) begin
      res_status = ST_BAD_PERM;
    end else if (zero_size || cp_rerr[SIZE_REGS]) begin
      res_status = ST_RANGE;
    end else begin
      res_status = ST_OK;
    end
  end

  assign res_src   = (res_status == ST_OK) ? cp_src[SIZE_REGS] : '0;
  assign res_valid = en && cp_valid[SIZE_REGS];

  // output register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r  <= skid_valid_r || res_valid;
      skid_valid_r <= 1'b0;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_src_r    <= skid_src_r;
        out_status_r <= skid_status_r;
      end else begin
        out_src_r    <= res_src;
        out_status_r <= res_status;
      end
    end else if (res_valid) begin
      skid_src_r    <= res_src;
      skid_status_r <= res_status;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.src_index = out_src_r;
  assign out_ch.status    = out_status_r;

  // skid register only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result with empty output register");

  // a result arriving at a stalled output lands in the skid register
  a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && out_valid_r && !out_ch.ready) |=> skid_valid_r)
    else $error("result in flight lost at stalled output");

  // error results carry a zero source index
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_src_r == '0))
    else $error("error result with nonzero source index");

  // bad permutation status only with a bad map configured
  a_bad_perm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_BAD_PERM)) |-> bad_perm)
    else $error("bad permutation status with a valid map");

endmodule

// ----- test/ttim_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttim_checker
// Watches both channels of the index map unit, predicts every source index
// and status from a private copy of the registers and compares in order.
// ----------------------------------------------------------------------------
module ttim_checker
  import ttim_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [23:0]           in_index,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [23:0]           out_src,
  input  status_t               out_status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [12:0]           cfg_data,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [23:0] src;
    status_t     status;
  } src_result_t;

  logic [2:0]  dims_reg;
  logic [12:0] size_reg [SIZE_REGS];
  logic [7:0]  perm_reg;
  src_result_t src_queue [$];

  assign pending = src_queue.size();

  function automatic src_result_t map_index(logic [23:0] idx);
    src_result_t r;
    int unsigned n;
    longint unsigned count, rem, acc, factor;
    longint unsigned coord [SIZE_REGS];
    logic [1:0] sel;
    bit bad;
    n = (dims_reg > SIZE_REGS) ? SIZE_REGS : dims_reg;
    count = 1;
    bad = 0;
    rem = idx;
    acc = 0;
    factor = 1;
    for (int j = 0; j < SIZE_REGS; j++) coord[j] = 0;
    for (int j = 0; j < n; j++) begin
      sel = perm_reg[2*j +: 2];
      if (sel >= n) bad = 1;
      count = count * size_reg[j];
    end
    r.src = '0;
    if (bad) begin
      r.status = ST_BAD_PERM;
    end else if (idx >= count) begin
      r.status = ST_RANGE;
    end else begin
      for (int j = 0; j < n; j++) begin
        coord[j] = rem % size_reg[j];
        rem = rem / size_reg[j];
      end
      for (int j = 0; j < n; j++) begin
        acc = acc + coord[perm_reg[2*j +: 2]] * factor;
        factor = factor * size_reg[j];
      end
      r.src = acc[23:0];
      r.status = ST_OK;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    src_result_t e;
    if (!rst_n) begin
      dims_reg <= DIM_COUNT_RST;
      for (int j = 0; j < SIZE_REGS; j++) size_reg[j] <= 13'd1;
      perm_reg <= PERM_MAP_RST;
      fail_count <= 0;
      src_queue.delete();
    end else begin
      if (in_valid && in_ready) src_queue = {src_queue, map_index(in_index)};
      if (out_valid && out_ready) begin
        if (src_queue.size() == 0) begin
          $error("result transfer with no expectation: src_index %0d", out_src);
          fail_count <= fail_count + 1;
        end else begin
          e = src_queue.pop_front();
          if (out_status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, out_status);
            fail_count <= fail_count + 1;
          end else if (out_src !== e.src) begin
            $error("src_index: expected %0d actual %0d", e.src, out_src);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_DIM_COUNT: dims_reg <= cfg_data[2:0];
          CFG_DIM0_SIZE: size_reg[0] <= cfg_data;
          CFG_DIM1_SIZE: size_reg[1] <= cfg_data;
          CFG_DIM2_SIZE: size_reg[2] <= cfg_data;
          CFG_DIM3_SIZE: size_reg[3] <= cfg_data;
          CFG_PERM_MAP:  perm_reg <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the index map unit through several register settings with directed
// and random indexes under changing idle patterns; the checker compares.
// ----------------------------------------------------------------------------
module tb;
  import ttim_pkg::*;

  localparam int DRAIN_CYCLES = 4*24 + 5 + 20;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_LEN = 400;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [12:0] cfg_data;
  int fail_count;
  int pending;
  int idle_pct;
  int stall_pct;
  int hold_cycles;
  int hold_req;
  int hold_seen;
  int quiet_cycles;

  ttim_in_if  #(.INDEX_BITS(24)) in_ch ();
  ttim_out_if #(.INDEX_BITS(24)) out_ch ();

  tensor_transpose_index_map_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  ttim_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_index(in_ch.out_index),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_src(out_ch.src_index),
    .out_status(out_ch.status),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= 0;
      hold_seen <= 0;
    end else if (hold_req != hold_seen) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= HOLD_LEN;
      hold_seen <= hold_req;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_index(input logic [23:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.out_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [12:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_shape(input logic [2:0] n, input logic [12:0] s0, input logic [12:0] s1,
                           input logic [12:0] s2, input logic [12:0] s3,
                           input logic [7:0] perm);
    write_reg(CFG_DIM_COUNT, {10'd0, n});
    write_reg(CFG_DIM0_SIZE, s0);
    write_reg(CFG_DIM1_SIZE, s1);
    write_reg(CFG_DIM2_SIZE, s2);
    write_reg(CFG_DIM3_SIZE, s3);
    write_reg(CFG_PERM_MAP, {5'd0, perm});
  endtask

  // random permutation of n dimensions, now and then a random map; mostly small sizes
  task automatic random_shape();
    int n;
    int p [4];
    int k, t;
    logic [7:0] perm;
    logic [12:0] s [4];
    n = $urandom_range(4, 1);
    for (int j = 0; j < 4; j++) begin
      p[j] = j;
      s[j] = ($urandom_range(9) == 0) ? 13'($urandom_range(4096, 1)) : 13'($urandom_range(12, 1));
    end
    for (int j = n - 1; j > 0; j--) begin
      k = $urandom_range(j);
      t = p[j]; p[j] = p[k]; p[k] = t;
    end
    perm = 8'($urandom);
    for (int j = 0; j < n; j++) perm[2*j +: 2] = 2'(p[j]);
    if ($urandom_range(9) == 0) perm = 8'($urandom);
    set_shape(3'(n), s[0], s[1], s[2], s[3], perm);
  endtask

  function automatic logic [23:0] pick_index(int span);
    if ($urandom_range(9) == 0) return 24'($urandom);
    return 24'($urandom_range(span));
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.out_index = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    rst_n = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: single element
    send_index(24'd0);
    send_index(24'd1);
    send_index(24'hFFFFFF);
    drain();

    // large sizes, full 4-d reversal; huge element count
    set_shape(3'd4, 13'd4096, 13'd4096, 13'd4096, 13'd4096, 8'h1B);
    send_index(24'd0);
    send_index(24'hFFFFFF);
    send_index(24'hAAAAAA);
    send_index(24'h555555);
    drain();
    // unequal sizes, last index and one beyond the element count
    set_shape(3'd2, 13'd4096, 13'd3, 13'd1, 13'd1, 8'hE1);
    send_index(24'd12287);
    send_index(24'd12288);
    send_index(24'd5000);
    drain();
    // bad permutation entry, both errors at once, count out of range, zero size
    set_shape(3'd2, 13'd2, 13'd2, 13'd1, 13'd1, 8'hE6);
    send_index(24'd1);
    send_index(24'd9);
    drain();
    set_shape(3'd7, 13'd2, 13'd3, 13'd4, 13'd5, 8'h4E);
    send_index(24'd119);
    send_index(24'd120);
    send_index(24'd17);
    drain();
    set_shape(3'd0, 13'd5, 13'd5, 13'd5, 13'd5, 8'hFF);
    send_index(24'd0);
    send_index(24'd1);
    drain();
    set_shape(3'd3, 13'd4, 13'd0, 13'd4, 13'd1, 8'hE4);
    send_index(24'd0);
    send_index(24'd3);
    drain();
    set_shape(3'd1, 13'h1FFF, 13'd1, 13'd1, 13'd1, 8'h00);
    send_index(24'd8190);
    send_index(24'd8191);
    drain();

    // random phases under different idle patterns
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      random_shape();
      // long receiver hold-off while the sender keeps offering, so the unit fills
      if (ph == 4) hold_req = hold_req + 1;
      for (int i = 0; i < ((ph == 4) ? 160 : 68); i++) begin
        send_index(pick_index(($urandom_range(1) == 0) ? 200 : 3000));
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
